// File: rtl/bpa_pkg.sv
// bpa_pkg: shared types and constants for the bitmap page allocator
// used by bpa_ctrl, bpa_dp and bitmap_page_allocator; no dependencies
`timescale 1ns / 1ps

package bpa_pkg;

    localparam int MAX_PAGES_DEF     = 65536;
    localparam int MAP_WORD_BITS_DEF = 32;
    localparam int CFG_ADDR_W        = 3;
    localparam int CFG_DATA_W        = 32;
    localparam int TP_W              = 17;
    localparam logic [TP_W-1:0] TP_RESET = 17'd65536;
    localparam logic [CFG_ADDR_W-1:0] ADDR_TOTAL_PAGES = 3'd0;

    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_FREE    = 2'd1;
    localparam logic [1:0] CMD_RESERVE = 2'd2;
    localparam logic [1:0] CMD_QUERY   = 2'd3;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_DEC,
        ST_SRD,
        ST_SBIT,
        ST_MRD,
        ST_MWR,
        ST_QRD,
        ST_QBIT,
        ST_FIN
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLR,
        OP_LOAD,
        OP_SRD,
        OP_SCAN,
        OP_MRD,
        OP_MWR,
        OP_QRD,
        OP_QBIT,
        OP_EMIT
    } op_t;

    typedef struct packed {
        logic       clr_done;
        logic [1:0] cmd;
        logic       tp_zero;
        logic       term;
        logic       pass2;
        logic       hit;
        logic       need_rd;
        logic       mark_done;
        logic       q_inside;
        logic       out_free;
    } dp_stat_t;

endpackage

// File: rtl/bitmap_page_allocator.sv
// bitmap_page_allocator: one used bit per page, next-fit allocate, free, reserve, query
// allocate reads each 32-page map word, then tests its pages one by one and skips a fully
//   used word whole; free/reserve read each map word, then write it back with the run marked
// one command at a time, taken only once the last result has been emitted; a query reads one map word
// reset: a sweep sets every map word to all used, no command is taken meanwhile
// depends on bpa_pkg, bpa_ctrl, bpa_dp
`timescale 1ns / 1ps

module bitmap_page_allocator #(
    parameter int MAX_PAGES     = bpa_pkg::MAX_PAGES_DEF,
    parameter int MAP_WORD_BITS = bpa_pkg::MAP_WORD_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // command beat
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     cmd,
    input  logic [15:0]                    start_page,
    input  logic [16:0]                    page_count,
    // result beat
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           ok,
    output logic [15:0]                    found_page,
    output logic                           page_used,
    // register port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bpa_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [bpa_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [bpa_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);

    logic [bpa_pkg::TP_W-1:0] total_pages_reg;
    bpa_pkg::dp_stat_t        stat;
    bpa_pkg::op_t             op;

    // total pages register, written in the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_pages_reg <= bpa_pkg::TP_RESET;
        end
        else if (psel && penable && pwrite && paddr == bpa_pkg::ADDR_TOTAL_PAGES)
        begin
            total_pages_reg <= pwdata[bpa_pkg::TP_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == bpa_pkg::ADDR_TOTAL_PAGES)
                  ? bpa_pkg::CFG_DATA_W'(total_pages_reg) : '0;

    // sequencer
    bpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .stat     (stat),
        .in_stall (in_stall),
        .op       (op)
    );

    // bitmap and scan datapath
    bpa_dp #(
        .MAX_PAGES     (MAX_PAGES),
        .MAP_WORD_BITS (MAP_WORD_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .total_pages (total_pages_reg),
        .cmd         (cmd),
        .start_page  (start_page),
        .page_count  (page_count),
        .out_stall   (out_stall),
        .stat        (stat),
        .out_valid   (out_valid),
        .ok          (ok),
        .found_page  (found_page),
        .page_used   (page_used)
    );

endmodule

// File: rtl/bpa_ctrl.sv
// bpa_ctrl: sequencer for the page allocator
// drives bpa_dp through op codes, reads its status; uses bpa_pkg
`timescale 1ns / 1ps

module bpa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  bpa_pkg::dp_stat_t stat,
    output logic              in_stall,
    output bpa_pkg::op_t      op
);

    bpa_pkg::state_t state_reg;
    bpa_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bpa_pkg::ST_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bpa_pkg::ST_CLR:
            begin
                if (stat.clr_done)
                begin
                    state_next = bpa_pkg::ST_IDLE;
                end
            end
            bpa_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = bpa_pkg::ST_DEC;
                end
            end
            bpa_pkg::ST_DEC:
            begin
                case (stat.cmd)
                    bpa_pkg::CMD_ALLOC:
                    begin
                        state_next = stat.tp_zero ? bpa_pkg::ST_FIN : bpa_pkg::ST_SRD;
                    end
                    bpa_pkg::CMD_QUERY:
                    begin
                        state_next = bpa_pkg::ST_QRD;
                    end
                    default:
                    begin
                        state_next = bpa_pkg::ST_MRD;
                    end
                endcase
            end
            bpa_pkg::ST_SRD:
            begin
                state_next = bpa_pkg::ST_SBIT;
            end
            bpa_pkg::ST_SBIT:
            begin
                if (stat.term && stat.pass2)
                begin
                    state_next = bpa_pkg::ST_FIN;
                end
                else if (stat.hit)
                begin
                    state_next = bpa_pkg::ST_MRD;
                end
                else if (stat.need_rd)
                begin
                    state_next = bpa_pkg::ST_SRD;
                end
            end
            bpa_pkg::ST_MRD:
            begin
                state_next = stat.mark_done ? bpa_pkg::ST_FIN : bpa_pkg::ST_MWR;
            end
            bpa_pkg::ST_MWR:
            begin
                state_next = bpa_pkg::ST_MRD;
            end
            bpa_pkg::ST_QRD:
            begin
                state_next = stat.q_inside ? bpa_pkg::ST_QBIT : bpa_pkg::ST_FIN;
            end
            bpa_pkg::ST_QBIT:
            begin
                state_next = bpa_pkg::ST_FIN;
            end
            bpa_pkg::ST_FIN:
            begin
                if (stat.out_free)
                begin
                    state_next = bpa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bpa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        op       = bpa_pkg::OP_NONE;
        case (state_reg)
            bpa_pkg::ST_CLR:
            begin
                op = bpa_pkg::OP_CLR;
            end
            bpa_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                op       = in_valid ? bpa_pkg::OP_LOAD : bpa_pkg::OP_NONE;
            end
            bpa_pkg::ST_SRD:
            begin
                op = bpa_pkg::OP_SRD;
            end
            bpa_pkg::ST_SBIT:
            begin
                op = bpa_pkg::OP_SCAN;
            end
            bpa_pkg::ST_MRD:
            begin
                op = bpa_pkg::OP_MRD;
            end
            bpa_pkg::ST_MWR:
            begin
                op = bpa_pkg::OP_MWR;
            end
            bpa_pkg::ST_QRD:
            begin
                op = bpa_pkg::OP_QRD;
            end
            bpa_pkg::ST_QBIT:
            begin
                op = bpa_pkg::OP_QBIT;
            end
            bpa_pkg::ST_FIN:
            begin
                op = stat.out_free ? bpa_pkg::OP_EMIT : bpa_pkg::OP_NONE;
            end
            default:
            begin
                op = bpa_pkg::OP_NONE;
            end
        endcase
    end

endmodule

// File: rtl/bpa_dp.sv
// bpa_dp: bitmap memory, scan and mark datapath, result register
// executes op codes from bpa_ctrl; uses bpa_pkg
`timescale 1ns / 1ps

module bpa_dp #(
    parameter int MAX_PAGES     = bpa_pkg::MAX_PAGES_DEF,
    parameter int MAP_WORD_BITS = bpa_pkg::MAP_WORD_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  bpa_pkg::op_t             op,
    input  logic [bpa_pkg::TP_W-1:0] total_pages,
    input  logic [1:0]               cmd,
    input  logic [15:0]              start_page,
    input  logic [16:0]              page_count,
    input  logic                     out_stall,
    output bpa_pkg::dp_stat_t        stat,
    output logic                     out_valid,
    output logic                     ok,
    output logic [15:0]              found_page,
    output logic                     page_used
);

    localparam int W     = MAP_WORD_BITS;
    localparam int LB    = $clog2(W);
    localparam int WORDS = (MAX_PAGES + W - 1) / W;
    localparam int WA    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PW    = $clog2(MAX_PAGES + W) + 1;
    localparam int CW    = $clog2(MAX_PAGES);
    localparam int XW    = (PW > 18) ? PW + 1 : 19;

    logic [W-1:0] mem [WORDS];
    logic [W-1:0] rdata_reg;
    logic         re;
    logic         we;
    logic [WA-1:0] raddr;
    logic [WA-1:0] waddr;
    logic [W-1:0]  wdata;

    logic [WA:0]   clr_cnt_reg;
    logic [CW-1:0] cursor_reg;
    logic          out_valid_reg;

    logic [1:0]    cmd_reg;
    logic [15:0]   start_reg;
    logic [16:0]   count_reg;
    logic [PW-1:0] tp_reg;
    logic [PW-1:0] q_reg;
    logic [PW-1:0] hi_reg;
    logic [PW-1:0] run_len_reg;
    logic [PW-1:0] run_start_reg;
    logic          pass_reg;
    logic [PW-1:0] mq_reg;
    logic [PW-1:0] mend_reg;
    logic          bad_reg;
    logic          res_ok_reg;
    logic [CW-1:0] res_found_reg;
    logic          res_used_reg;
    logic          ok_reg;
    logic [15:0]   found_reg;
    logic          used_reg;

    logic [PW-1:0] tp_clip;
    logic [XW-1:0] need;
    logic          cur_bit;
    logic          word_full;
    logic          term;
    logic          hit;
    logic [PW-1:0] where;
    logic [PW-1:0] hi2;
    logic [XW-1:0] in_end;
    logic [XW-1:0] in_mend;
    logic [XW-1:0] hit_end;
    logic [PW-1:0] mbase;
    logic [W-1:0]  mask;
    logic          mark_used;
    logic          mark_done;
    logic          q_inside;

    // managed pages: register clipped at the map size
    assign tp_clip = (XW'(total_pages) > XW'(MAX_PAGES)) ? PW'(MAX_PAGES) : PW'(total_pages);
    assign need    = (count_reg == '0) ? XW'(1) : XW'(count_reg);
    assign cur_bit   = rdata_reg[q_reg[LB-1:0]];
    assign word_full = &rdata_reg;
    assign term = (XW'(q_reg) >= XW'(tp_reg))
               || ((run_len_reg == '0) && (XW'(q_reg) >= XW'(hi_reg)));
    assign hit  = !term && !cur_bit && ((XW'(run_len_reg) + XW'(1)) >= need);
    assign where = (run_len_reg == '0) ? q_reg : run_start_reg;
    assign hi2   = (XW'(cursor_reg) < XW'(tp_reg)) ? PW'(cursor_reg) : tp_reg;

    assign in_end  = XW'(start_page) + XW'(page_count);
    assign in_mend = (in_end > XW'(tp_clip)) ? XW'(tp_clip) : in_end;
    assign hit_end = (XW'(where) + XW'(count_reg) > XW'(tp_reg))
                   ? XW'(tp_reg) : XW'(where) + XW'(count_reg);

    assign mbase     = (mq_reg >> LB) << LB;
    assign mark_used = (cmd_reg != bpa_pkg::CMD_FREE);
    assign mark_done = XW'(mq_reg) >= XW'(mend_reg);
    assign q_inside  = XW'(start_reg) < XW'(tp_reg);

    always_comb
    begin
        for (int i = 0; i < W; i++)
        begin
            mask[i] = (XW'(mbase) + XW'(i) >= XW'(mq_reg))
                   && (XW'(mbase) + XW'(i) < XW'(mend_reg));
        end
    end

    // single read port, registered data
    always_comb
    begin
        re    = 1'b0;
        raddr = '0;
        case (op)
            bpa_pkg::OP_SRD:
            begin
                re    = 1'b1;
                raddr = WA'(q_reg >> LB);
            end
            bpa_pkg::OP_MRD:
            begin
                re    = !mark_done;
                raddr = WA'(mq_reg >> LB);
            end
            bpa_pkg::OP_QRD:
            begin
                re    = q_inside;
                raddr = WA'(start_reg >> LB);
            end
            default:
            begin
                re = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = WA'(mq_reg >> LB);
        wdata = mark_used ? (rdata_reg | mask) : (rdata_reg & ~mask);
        if (op == bpa_pkg::OP_CLR)
        begin
            we    = 1'b1;
            waddr = clr_cnt_reg[WA-1:0];
            wdata = '1;
        end
        else if (op == bpa_pkg::OP_MWR)
        begin
            we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            cursor_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (op == bpa_pkg::OP_CLR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (op == bpa_pkg::OP_SCAN && hit)
            begin
                cursor_reg <= CW'(where);
            end
            if (op == bpa_pkg::OP_EMIT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        case (op)
            bpa_pkg::OP_LOAD:
            begin
                cmd_reg       <= cmd;
                start_reg     <= start_page;
                count_reg     <= page_count;
                tp_reg        <= tp_clip;
                q_reg         <= PW'(cursor_reg);
                hi_reg        <= tp_clip;
                run_len_reg   <= '0;
                pass_reg      <= 1'b0;
                bad_reg       <= 1'b0;
                res_ok_reg    <= 1'b0;
                res_found_reg <= '0;
                res_used_reg  <= 1'b0;
                mend_reg      <= PW'(in_mend);
                mq_reg        <= (XW'(start_page) >= in_mend) ? PW'(in_mend) : PW'(start_page);
            end
            bpa_pkg::OP_SCAN:
            begin
                if (term)
                begin
                    if (!pass_reg)
                    begin
                        pass_reg    <= 1'b1;
                        q_reg       <= '0;
                        run_len_reg <= '0;
                        hi_reg      <= hi2;
                    end
                end
                else if (hit)
                begin
                    res_ok_reg    <= 1'b1;
                    res_found_reg <= CW'(where);
                    mq_reg        <= where;
                    mend_reg      <= PW'(hit_end);
                end
                else if (word_full || cur_bit)
                begin
                    run_len_reg <= '0;
                    q_reg       <= word_full ? ((q_reg >> LB) + 1'b1) << LB : q_reg + 1'b1;
                end
                else
                begin
                    if (run_len_reg == '0)
                    begin
                        run_start_reg <= q_reg;
                    end
                    run_len_reg <= run_len_reg + 1'b1;
                    q_reg       <= q_reg + 1'b1;
                end
            end
            bpa_pkg::OP_MRD:
            begin
                if (mark_done && cmd_reg != bpa_pkg::CMD_ALLOC)
                begin
                    res_ok_reg <= !bad_reg;
                end
            end
            bpa_pkg::OP_MWR:
            begin
                if (mark_used ? |(rdata_reg & mask) : |(~rdata_reg & mask))
                begin
                    bad_reg <= 1'b1;
                end
                mq_reg <= mbase + PW'(W);
            end
            bpa_pkg::OP_QRD:
            begin
                if (!q_inside)
                begin
                    res_used_reg <= 1'b1;
                end
            end
            bpa_pkg::OP_QBIT:
            begin
                res_ok_reg   <= 1'b1;
                res_used_reg <= rdata_reg[start_reg[LB-1:0]];
            end
            bpa_pkg::OP_EMIT:
            begin
                ok_reg    <= res_ok_reg;
                found_reg <= 16'(res_found_reg);
                used_reg  <= res_used_reg;
            end
            default:
            begin
                bad_reg <= bad_reg;
            end
        endcase
    end

    assign stat.clr_done  = (clr_cnt_reg == (WA+1)'(WORDS));
    assign stat.cmd       = cmd_reg;
    assign stat.tp_zero   = (tp_reg == '0);
    assign stat.term      = term;
    assign stat.pass2     = pass_reg;
    assign stat.hit       = hit;
    assign stat.need_rd   = term || word_full || (&q_reg[LB-1:0]);
    assign stat.mark_done = mark_done;
    assign stat.q_inside  = q_inside;
    assign stat.out_free  = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign ok         = ok_reg;
    assign found_page = found_reg;
    assign page_used  = used_reg;

endmodule

// File: tb/bitmap_page_allocator_tb.sv
// bitmap_page_allocator_tb: self-checking testbench for the bitmap page allocator
// drives command beats and register writes, predicts every result beat in-line
// depends on bpa_pkg and bitmap_page_allocator
`timescale 1ns / 1ps

module bitmap_page_allocator_tb;

    localparam int NPAGES = 65536;
    localparam int WDOG_LIMIT = 400000;

    typedef struct packed {
        logic        ok;
        logic [15:0] found_page;
        logic        page_used;
    } alloc_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  cmd;
    logic [15:0] start_page;
    logic [16:0] page_count;
    logic        out_valid;
    logic        out_stall;
    logic        ok;
    logic [15:0] found_page;
    logic        page_used;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [bpa_pkg::CFG_ADDR_W-1:0] paddr;
    logic [bpa_pkg::CFG_DATA_W-1:0] pwdata;
    logic [bpa_pkg::CFG_DATA_W-1:0] prdata;
    logic        pready;

    // predictor state: one bit per page, the next-fit cursor and the page limit
    bit          page_map [NPAGES];
    int unsigned fit_cursor;
    int unsigned page_limit;

    alloc_result_t pending_results[$];
    int          fail_count;
    int          idle_cycles = 0;
    int          send_idle_pct;
    int          recv_stall_pct;

    bitmap_page_allocator DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .cmd(cmd), .start_page(start_page), .page_count(page_count),
        .out_valid(out_valid), .out_stall(out_stall),
        .ok(ok), .found_page(found_page), .page_used(page_used),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // first start in [lo, hi) of need free pages that ends by the page limit
    function automatic bit find_free_run(input int unsigned lo, input int unsigned hi,
                                         input int unsigned need,
                                         output int unsigned run_at);
        int unsigned q;
        int unsigned run_len;
        run_len = 0;
        run_at = 0;
        for (q = lo; q < page_limit; q++)
        begin
            if (run_len == 0 && q >= hi)
                return 0;
            if (page_map[q])
            begin
                run_len = 0;
                continue;
            end
            if (run_len == 0)
                run_at = q;
            run_len++;
            if (run_len >= need)
                return 1;
        end
        return 0;
    endfunction

    // sets or clears a run clipped at the limit; 1 if every page flipped
    function automatic bit mark_pages(input int unsigned first, input int unsigned cnt,
                                      input bit used);
        int unsigned stop;
        int unsigned p;
        bit good;
        good = 1;
        stop = first + cnt;
        if (stop > page_limit)
            stop = page_limit;
        for (p = first; p < stop; p++)
        begin
            if (page_map[p] == used)
                good = 0;
            page_map[p] = used;
        end
        return good;
    endfunction

    function automatic alloc_result_t predict_command(input logic [1:0] c,
                                                      input logic [15:0] sp,
                                                      input logic [16:0] pc);
        alloc_result_t r;
        int unsigned need;
        int unsigned run_at;
        int unsigned hi2;
        bit hit;
        r = '0;
        case (c)
            bpa_pkg::CMD_ALLOC:
            begin
                need = (pc == 0) ? 1 : pc;
                hi2 = (fit_cursor < page_limit) ? fit_cursor : page_limit;
                hit = 0;
                if (page_limit != 0)
                begin
                    hit = find_free_run(fit_cursor, page_limit, need, run_at);
                    if (!hit)
                        hit = find_free_run(0, hi2, need, run_at);
                end
                if (hit)
                begin
                    void'(mark_pages(run_at, pc, 1'b1));
                    fit_cursor = run_at;
                    r.ok = 1'b1;
                    r.found_page = run_at[15:0];
                end
            end
            bpa_pkg::CMD_FREE:    r.ok = mark_pages(sp, pc, 1'b0);
            bpa_pkg::CMD_RESERVE: r.ok = mark_pages(sp, pc, 1'b1);
            default:
            begin
                if (sp < page_limit)
                begin
                    r.ok = 1'b1;
                    r.page_used = page_map[sp];
                end
                else
                begin
                    r.ok = 1'b0;
                    r.page_used = 1'b1;
                end
            end
        endcase
        return r;
    endfunction

    // sends one command beat and records its expected result
    // valid stays high after the beat until the next send or drain drops it
    task automatic send_command(input logic [1:0] c, input logic [15:0] sp,
                                input logic [16:0] pc);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= c;
        start_page <= sp;
        page_count <= pc;
        pending_results.push_back(predict_command(c, sp, pc));
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // a beat may still be in flight behind the last result
        repeat (20) @(posedge clk);
    endtask

    // register writes only while idle: setup cycle then access cycle
    task automatic write_total_pages(input logic [16:0] value);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= bpa_pkg::ADDR_TOTAL_PAGES;
        pwdata  <= {15'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        page_limit = (value > NPAGES) ? NPAGES : value;
    endtask

    task automatic set_idling(input int s, input int r);
        send_idle_pct  = s;
        recv_stall_pct = r;
    endtask

    // random count biased to short runs, occasionally long
    function automatic logic [16:0] pick_count();
        int unsigned k;
        k = $urandom_range(99);
        if (k < 70)
            return 17'($urandom_range(8));
        if (k < 92)
            return 17'($urandom_range(80));
        if (k < 97)
            return 17'($urandom_range(600));
        return 17'($urandom_range(65536, 60000));
    endfunction

    task automatic test_directed();
        write_total_pages(17'd64);
        send_command(bpa_pkg::CMD_QUERY, 16'd0, 17'd0);        // page used after reset
        send_command(bpa_pkg::CMD_ALLOC, 16'd0, 17'd1);        // nothing free yet
        send_command(bpa_pkg::CMD_FREE, 16'd0, 17'd64);
        send_command(bpa_pkg::CMD_FREE, 16'd3, 17'd1);         // already free
        send_command(bpa_pkg::CMD_ALLOC, 16'hffff, 17'd0);     // zero pages, only moves cursor
        send_command(bpa_pkg::CMD_ALLOC, 16'd0, 17'd10);
        send_command(bpa_pkg::CMD_ALLOC, 16'd0, 17'd65);       // too long
        send_command(bpa_pkg::CMD_RESERVE, 16'd5, 17'd2);      // already used
        send_command(bpa_pkg::CMD_RESERVE, 16'd60, 17'h1ffff); // run past the end
        send_command(bpa_pkg::CMD_FREE, 16'hffff, 17'd5);      // wholly outside
        send_command(bpa_pkg::CMD_QUERY, 16'd63, 17'h1ffff);
        send_command(bpa_pkg::CMD_QUERY, 16'd64, 17'd0);       // query outside
        send_command(bpa_pkg::CMD_QUERY, 16'hffff, 17'd0);
        send_command(bpa_pkg::CMD_ALLOC, 16'd0, 17'd40);
        write_total_pages(17'd20);                             // cursor now below the new limit
        send_command(bpa_pkg::CMD_FREE, 16'd12, 17'd4);
        send_command(bpa_pkg::CMD_ALLOC, 16'd0, 17'd3);
        write_total_pages(17'd0);
        send_command(bpa_pkg::CMD_ALLOC, 16'd0, 17'd0);        // zero pages managed
        send_command(bpa_pkg::CMD_QUERY, 16'd0, 17'd0);
        write_total_pages(17'h1ffff);                          // above the maximum
        send_command(bpa_pkg::CMD_FREE, 16'hfff0, 17'd16);
        send_command(bpa_pkg::CMD_ALLOC, 16'd0, 17'd16);
        send_command(bpa_pkg::CMD_QUERY, 16'hffff, 17'd0);
        send_command(bpa_pkg::CMD_RESERVE, 16'd0, 17'd65536);
        send_command(bpa_pkg::CMD_FREE, 16'd0, 17'd65536);
    endtask

    // mostly well-formed traffic near a chosen window of pages
    task automatic test_random(input int n_items, input logic [16:0] limit,
                               input int s, input int r);
        int i;
        int unsigned span;
        logic [1:0] c;
        logic [15:0] sp;
        write_total_pages(limit);
        set_idling(s, r);
        span = (page_limit > 0) ? page_limit + 8 : 64;
        if (span > 65535)
            span = ($urandom_range(3) == 0) ? 65535 : 2048;
        for (i = 0; i < n_items; i++)
        begin
            c  = 2'($urandom_range(3));
            sp = ($urandom_range(15) == 0) ? 16'($urandom) : 16'($urandom_range(span));
            send_command(c, sp, pick_count());
        end
    endtask

    // sender holds off until all results are back
    task automatic test_drain_pause();
        send_command(bpa_pkg::CMD_ALLOC, 16'd0, 17'd2);
        send_command(bpa_pkg::CMD_QUERY, 16'd1, 17'd0);
        wait_drained();
        send_command(bpa_pkg::CMD_FREE, 16'd0, 17'd4);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0; cmd = '0; start_page = '0; page_count = '0;
        out_stall = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        fail_count = 0;
        set_idling(0, 0);
        foreach (page_map[i])
            page_map[i] = 1'b1;
        fit_cursor = 0;
        page_limit = NPAGES;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(350, 17'd256, 0, 0);
        test_random(300, 17'd100, 54, 0);
        test_drain_pause();
        test_random(300, 17'd1024, 0, 54);
        test_random(250, 17'd33, 9, 9);
        test_random(200, 17'd65536, 0, 0);
        test_random(100, 17'd1, 54, 54);
        wait_drained();
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // receiver stall pattern
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // result checker compares each accepted result beat with the oldest prediction
    always @(posedge clk)
    begin
        alloc_result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing expected");
                fail_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (ok !== exp_r.ok)
                begin
                    $error("ok: expected %0d actual %0d", exp_r.ok, ok);
                    fail_count++;
                end
                if (found_page !== exp_r.found_page)
                begin
                    $error("found_page: expected %0d actual %0d",
                           exp_r.found_page, found_page);
                    fail_count++;
                end
                if (page_used !== exp_r.page_used)
                begin
                    $error("page_used: expected %0d actual %0d",
                           exp_r.page_used, page_used);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles without any accepted beat or register access; covers the reset sweep too
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

endmodule

// File: files.f
rtl/bpa_pkg.sv
rtl/bpa_ctrl.sv
rtl/bpa_dp.sv
rtl/bitmap_page_allocator.sv
tb/bitmap_page_allocator_tb.sv
